FILE: sv/i2cms_pkg.sv
`default_nettype none

package i2cms_pkg;

   localparam int unsigned BITS_PER_BYTE = 8;

   // Phase at which a write releases SDA for the acknowledge, and at which a
   // read drives its own acknowledge.
   localparam logic [4:0] WRITE_ACK_PHASE = 5'(3 * BITS_PER_BYTE);
   localparam logic [4:0] READ_ACK_PHASE  = 5'(2 * BITS_PER_BYTE);

   typedef enum logic [1:0] {
      OP_START = 2'd0,
      OP_STOP  = 2'd1,
      OP_WRITE = 2'd2,
      OP_READ  = 2'd3
   } opcode_type;

   typedef struct packed {
      logic                     command_valid;
      opcode_type               opcode;
      logic [BITS_PER_BYTE-1:0] write_byte;
      logic                     send_ack;
      logic                     sda_line;
   } req_type;

   typedef struct packed {
      logic                     scl_level;
      logic                     sda_release;
      logic                     busy_res;
      logic                     done_res;
      logic [BITS_PER_BYTE-1:0] read_byte;
      logic                     nack_seen;
   } rsp_type;

   typedef struct packed {
      logic busy;
      logic scl;
      logic sda;
   } status_type;

endpackage

`default_nettype wire

FILE: sv/i2c_master_bit_sequencer.sv
// I2C master bit sequencer.
// Each item on the req_ channel is one bit-period tick: it carries the sampled
// SDA level and, optionally, a start, stop, write-byte or read-byte command.
// A command is taken only on a tick at which the engine is idle; otherwise it
// is ignored and the running command carries on.
// Every accepted item yields exactly one item on the rsp_ channel with the SCL
// level, the open-drain SDA drive (1 releases the line), busy and done flags,
// the last byte read and the acknowledge seen by the last write.
// The result of an accepted item is registered and is valid in the cycle after
// it is accepted. One item is taken per cycle unless the receiver stalls; the
// tick logic is a single pass between the engine state and the result register.
// If the receiver stalls, the result register holds its item and req_ready
// falls, so no tick is taken until the result is collected.
// After reset the engine is idle, both lines are released and no result is
// pending.
`default_nettype none

module i2c_master_bit_sequencer (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   output logic               req_ready,
   input  i2cms_pkg::req_type req_data,
   output logic               rsp_valid,
   input  wire                rsp_ready,
   output i2cms_pkg::rsp_type rsp_data
);

   logic                  req_fire;
   i2cms_pkg::rsp_type    step_rsp;
   i2cms_pkg::status_type status;

   assign req_fire = req_valid && req_ready;

   i2cms_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .step   (req_fire),
      .req    (req_data),
      .rsp    (step_rsp),
      .status (status)
   );

   i2cms_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (req_fire),
      .load_data (step_rsp),
      .up_ready  (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   a_fire_gives_result: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> rsp_valid)
      else $error("accepted item produced no result");

   a_done_is_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.done_res |-> rsp_data.busy_res)
      else $error("done without busy");

   a_idle_keeps_lines: assert property (@(posedge clock) disable iff (reset)
      req_fire && !status.busy && !req_data.command_valid |=>
         !rsp_data.busy_res && rsp_data.scl_level == $past(status.scl) &&
         rsp_data.sda_release == $past(status.sda))
      else $error("idle tick changed the bus lines");

   a_done_ends_busy: assert property (@(posedge clock) disable iff (reset)
      req_fire && step_rsp.done_res |=> !status.busy)
      else $error("engine still busy after last tick");

endmodule

`default_nettype wire

FILE: sv/i2cms_engine.sv
`default_nettype none

module i2cms_engine (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   step,
   input  i2cms_pkg::req_type    req,
   output i2cms_pkg::rsp_type    rsp,
   output i2cms_pkg::status_type status
);

   localparam int unsigned BW = i2cms_pkg::BITS_PER_BYTE;

   i2cms_pkg::opcode_type cmd_ff, cmd_in;
   logic [4:0]    phase_ff, phase_in;
   logic [1:0]    sub_ff, sub_in;
   logic [BW-1:0] shift_ff, shift_in;
   logic          busy_ff, busy_in;
   logic          ack_ff, ack_in;
   logic          nack_ff, nack_in;
   logic [BW-1:0] rres_ff, rres_in;
   logic          scl_ff, scl_in;
   logic          sda_ff, sda_in;

   always_comb begin
      i2cms_pkg::opcode_type cmd;
      logic [4:0]    ph;
      logic [1:0]    sb;
      logic [BW-1:0] sh;
      logic          bz;
      logic          ak;
      logic          last;
      logic          scl_low_after;
      logic          sda_free_after;

      cmd            = cmd_ff;
      ph             = phase_ff;
      sb             = sub_ff;
      sh             = shift_ff;
      bz             = busy_ff;
      ak             = ack_ff;
      last           = 1'b0;
      scl_low_after  = 1'b0;
      sda_free_after = 1'b0;
      nack_in        = nack_ff;
      rres_in        = rres_ff;
      scl_in         = scl_ff;
      sda_in         = sda_ff;

      // A command is taken only while the engine is idle; it runs its first
      // phase on the same tick.
      if (!busy_ff && req.command_valid) begin
         cmd = req.opcode;
         ph  = '0;
         sb  = '0;
         bz  = 1'b1;
         if (req.opcode == i2cms_pkg::OP_WRITE) begin
            sh = req.write_byte;
         end
         if (req.opcode == i2cms_pkg::OP_READ) begin
            ak = req.send_ack;
            sh = '0;
         end
      end

      if (bz) begin
         unique case (cmd)
            i2cms_pkg::OP_START: begin
               if (ph == 5'd0) begin
                  sda_in = 1'b1;
                  scl_in = 1'b1;
               end else if (ph == 5'd1) begin
                  sda_in = 1'b0;
               end else begin
                  scl_in = 1'b0;
                  last   = 1'b1;
               end
            end
            i2cms_pkg::OP_STOP: begin
               if (ph == 5'd0) begin
                  sda_in = 1'b0;
               end else if (ph == 5'd1) begin
                  scl_in = 1'b1;
               end else begin
                  sda_in = 1'b1;
                  last   = 1'b1;
               end
            end
            i2cms_pkg::OP_WRITE: begin
               // sub_ff tracks the position within each three-tick bit.
               if (ph < i2cms_pkg::WRITE_ACK_PHASE) begin
                  if (sb == 2'd0) begin
                     sda_in = sh[BW-1];
                     sh     = {sh[BW-2:0], 1'b0};
                  end else if (sb == 2'd1) begin
                     scl_in = 1'b1;
                  end else begin
                     scl_in = 1'b0;
                  end
               end else if (ph == i2cms_pkg::WRITE_ACK_PHASE) begin
                  sda_in = 1'b1;
               end else begin
                  scl_in        = 1'b1;
                  nack_in       = req.sda_line;
                  last          = 1'b1;
                  scl_low_after = 1'b1;
               end
            end
            i2cms_pkg::OP_READ: begin
               if (ph < i2cms_pkg::READ_ACK_PHASE) begin
                  if (!ph[0]) begin
                     sda_in = 1'b1;
                     scl_in = 1'b1;
                     sh     = {sh[BW-2:0], req.sda_line};
                  end else begin
                     scl_in = 1'b0;
                  end
               end else begin
                  sda_in         = !ak;
                  scl_in         = 1'b1;
                  rres_in        = sh;
                  last           = 1'b1;
                  scl_low_after  = 1'b1;
                  sda_free_after = 1'b1;
               end
            end
            default: ;
         endcase
      end

      rsp.scl_level   = scl_in;
      rsp.sda_release = sda_in;
      rsp.busy_res    = bz;
      rsp.done_res    = last;
      rsp.read_byte   = rres_in;
      rsp.nack_seen   = nack_in;

      if (bz) begin
         if (scl_low_after) begin
            scl_in = 1'b0;
         end
         if (sda_free_after) begin
            sda_in = 1'b1;
         end
         if (last) begin
            bz = 1'b0;
            ph = '0;
         end else begin
            ph = ph + 5'd1;
         end
         sb = (sb == 2'd2) ? 2'd0 : sb + 2'd1;
      end

      cmd_in   = cmd;
      phase_in = ph;
      sub_in   = sb;
      shift_in = sh;
      busy_in  = bz;
      ack_in   = ak;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_ff   <= i2cms_pkg::OP_START;
         phase_ff <= '0;
         sub_ff   <= '0;
         shift_ff <= '0;
         busy_ff  <= 1'b0;
         ack_ff   <= 1'b0;
         nack_ff  <= 1'b0;
         rres_ff  <= '0;
         scl_ff   <= 1'b1;
         sda_ff   <= 1'b1;
      end else if (step) begin
         cmd_ff   <= cmd_in;
         phase_ff <= phase_in;
         sub_ff   <= sub_in;
         shift_ff <= shift_in;
         busy_ff  <= busy_in;
         ack_ff   <= ack_in;
         nack_ff  <= nack_in;
         rres_ff  <= rres_in;
         scl_ff   <= scl_in;
         sda_ff   <= sda_in;
      end
   end

   assign status.busy = busy_ff;
   assign status.scl  = scl_ff;
   assign status.sda  = sda_ff;

endmodule

`default_nettype wire

FILE: sv/i2cms_out_reg.sv
`default_nettype none

module i2cms_out_reg (
   input  wire                clock,
   input  wire                reset,
   input  wire                load,
   input  i2cms_pkg::rsp_type load_data,
   output logic               up_ready,
   output logic               rsp_valid,
   input  wire                rsp_ready,
   output i2cms_pkg::rsp_type rsp_data
);

   logic               valid_ff, valid_in;
   i2cms_pkg::rsp_type data_ff;

   // The register may be refilled in the same cycle as its item leaves.
   assign up_ready = !valid_ff || rsp_ready;
   assign valid_in = load || (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

`default_nettype wire

FILE: tb/sv/i2c_line_checker.sv
`default_nettype none

module i2c_line_checker (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   input  wire                req_ready,
   input  i2cms_pkg::req_type req_data,
   input  wire                rsp_valid,
   input  wire                rsp_ready,
   input  i2cms_pkg::rsp_type rsp_data,
   output int unsigned        mismatch_count,
   output int unsigned        lines_outstanding
);

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [4:0] TICKS_PER_WRITE_BIT = 5'd3;

   // Private copy of the bus engine state.
   i2cms_pkg::opcode_type cmd;
   logic [4:0]        phase;
   logic [7:0]        shifter;
   logic              engine_busy;
   logic              ack_choice;
   logic              nack_latched;
   logic [7:0]        last_read;
   logic              scl_drive;
   logic              sda_drive;

   i2cms_pkg::rsp_type expected_lines[$];

   initial begin
      mismatch_count    = 0;
      lines_outstanding = 0;
   end

   function automatic i2cms_pkg::rsp_type advance_bus_engine(input i2cms_pkg::req_type tick);
      i2cms_pkg::rsp_type lines;
      logic [4:0] p;
      logic       running;
      logic       finished;
      logic       drop_scl;
      logic       free_sda;
      finished = 1'b0;
      drop_scl = 1'b0;
      free_sda = 1'b0;
      // A command is only taken while the engine is idle.
      if (!engine_busy && tick.command_valid) begin
         cmd         = tick.opcode;
         phase       = '0;
         engine_busy = 1'b1;
         if (tick.opcode == i2cms_pkg::OP_WRITE) begin
            shifter = tick.write_byte;
         end
         if (tick.opcode == i2cms_pkg::OP_READ) begin
            ack_choice = tick.send_ack;
            shifter    = '0;
         end
      end
      running = engine_busy;
      p       = phase;
      if (running) begin
         case (cmd)
            i2cms_pkg::OP_START: begin
               if (p == 5'd0) begin
                  sda_drive = 1'b1;
                  scl_drive = 1'b1;
               end else if (p == 5'd1) begin
                  sda_drive = 1'b0;
               end else begin
                  scl_drive = 1'b0;
                  finished  = 1'b1;
               end
            end
            i2cms_pkg::OP_STOP: begin
               if (p == 5'd0) begin
                  sda_drive = 1'b0;
               end else if (p == 5'd1) begin
                  scl_drive = 1'b1;
               end else begin
                  sda_drive = 1'b1;
                  finished  = 1'b1;
               end
            end
            i2cms_pkg::OP_WRITE: begin
               if (p < i2cms_pkg::WRITE_ACK_PHASE) begin
                  if (p % TICKS_PER_WRITE_BIT == 5'd0) begin
                     sda_drive = shifter[7];
                     shifter   = {shifter[6:0], 1'b0};
                  end else if (p % TICKS_PER_WRITE_BIT == 5'd1) begin
                     scl_drive = 1'b1;
                  end else begin
                     scl_drive = 1'b0;
                  end
               end else if (p == i2cms_pkg::WRITE_ACK_PHASE) begin
                  sda_drive = 1'b1;
               end else begin
                  scl_drive    = 1'b1;
                  nack_latched = tick.sda_line;
                  finished     = 1'b1;
                  drop_scl     = 1'b1;
               end
            end
            default: begin
               if (p < i2cms_pkg::READ_ACK_PHASE) begin
                  if (!p[0]) begin
                     sda_drive = 1'b1;
                     scl_drive = 1'b1;
                     shifter   = {shifter[6:0], tick.sda_line};
                  end else begin
                     scl_drive = 1'b0;
                  end
               end else begin
                  sda_drive = !ack_choice;
                  scl_drive = 1'b1;
                  last_read = shifter;
                  finished  = 1'b1;
                  drop_scl  = 1'b1;
                  free_sda  = 1'b1;
               end
            end
         endcase
      end
      lines.scl_level   = scl_drive;
      lines.sda_release = sda_drive;
      lines.busy_res    = running;
      lines.done_res    = finished;
      lines.read_byte   = last_read;
      lines.nack_seen   = nack_latched;
      // After the reported last tick of a write or read SCL goes low; a read also releases SDA.
      if (running) begin
         if (drop_scl) begin
            scl_drive = 1'b0;
         end
         if (free_sda) begin
            sda_drive = 1'b1;
         end
         if (finished) begin
            engine_busy = 1'b0;
            phase       = '0;
         end else begin
            phase = phase + 5'd1;
         end
      end
      return lines;
   endfunction

   function automatic void check_field(input string name, input logic [7:0] want,
                                       input logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin
      i2cms_pkg::rsp_type want;
      if (reset) begin
         cmd          <= i2cms_pkg::OP_START;
         phase        <= '0;
         shifter      <= '0;
         engine_busy  <= 1'b0;
         ack_choice   <= 1'b0;
         nack_latched <= 1'b0;
         last_read    <= '0;
         scl_drive    <= 1'b1;
         sda_drive    <= 1'b1;
         expected_lines.delete();
         lines_outstanding <= 0;
      end else begin
         if (req_valid && req_ready) begin
            expected_lines.push_back(advance_bus_engine(req_data));
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_lines.size() == 0) begin
               $error("result item arrived with no tick waiting for it");
               mismatch_count++;
            end else begin
               want = expected_lines.pop_front();
               check_field("scl_level", 8'(want.scl_level), 8'(rsp_data.scl_level));
               check_field("sda_release", 8'(want.sda_release), 8'(rsp_data.sda_release));
               check_field("busy_res", 8'(want.busy_res), 8'(rsp_data.busy_res));
               check_field("done_res", 8'(want.done_res), 8'(rsp_data.done_res));
               check_field("read_byte", want.read_byte, rsp_data.read_byte);
               check_field("nack_seen", 8'(want.nack_seen), 8'(rsp_data.nack_seen));
            end
         end
         lines_outstanding <= expected_lines.size();
      end
   end

endmodule

`default_nettype wire

FILE: tb/sv/tb.sv
`default_nettype none

module tb;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned CYCLE_LIMIT   = 200000;
   localparam int unsigned TICKS_PER_RUN = 200;
   localparam int unsigned LONG_HOLD     = 80;
   localparam logic [1:0]  SDA_LOW       = 2'd0;
   localparam logic [1:0]  SDA_RELEASED  = 2'd1;
   localparam logic [1:0]  SDA_RANDOM    = 2'd2;

   logic               clock     = 1'b0;
   logic               reset     = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   i2cms_pkg::req_type req_data  = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   i2cms_pkg::rsp_type rsp_data;

   int unsigned mismatch_count;
   int unsigned lines_outstanding;
   int unsigned cycle_count  = 0;
   int unsigned ticks_sent   = 0;
   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   int unsigned hold_left     = 0;
   logic        hold_request  = 1'b0;
   logic        hold_served   = 1'b0;

   always #1 clock = ~clock;

   i2c_master_bit_sequencer dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   i2c_line_checker line_check (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_data          (req_data),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_data          (rsp_data),
      .mismatch_count    (mismatch_count),
      .lines_outstanding (lines_outstanding)
   );

   // Receiver: random stalls, plus one long hold-off so that the block backs up.
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_request && !hold_served) begin
         rsp_ready   <= 1'b0;
         hold_left   <= LONG_HOLD;
         hold_served <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   function automatic logic [7:0] random_byte();
      case ($urandom_range(7))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic offer_tick(input i2cms_pkg::req_type tick);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         req_data  <= i2cms_pkg::req_type'($urandom);
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_data  <= tick;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      ticks_sent++;
   endtask

   // Issues a command on an idle engine, then feeds the rest of its ticks.
   // Follow-up ticks may carry commands, which the busy engine must ignore.
   task automatic run_command(input i2cms_pkg::opcode_type op, input logic [7:0] data,
                              input logic ack, input logic [1:0] sda_mode,
                              input int unsigned noise_pct);
      i2cms_pkg::req_type tick;
      int unsigned length;
      case (op)
         i2cms_pkg::OP_START, i2cms_pkg::OP_STOP: length = 3;
         i2cms_pkg::OP_WRITE: length = 3 * i2cms_pkg::BITS_PER_BYTE + 2;
         default:             length = 2 * i2cms_pkg::BITS_PER_BYTE + 1;
      endcase
      tick.command_valid = 1'b1;
      tick.opcode        = op;
      tick.write_byte    = data;
      tick.send_ack      = ack;
      for (int unsigned i = 0; i < length; i++) begin
         if (i != 0) begin
            tick.command_valid = ($urandom_range(99) < noise_pct);
            tick.opcode        = i2cms_pkg::opcode_type'($urandom_range(3));
            tick.write_byte    = 8'($urandom);
            tick.send_ack      = 1'($urandom);
         end
         tick.sda_line = (sda_mode == SDA_RANDOM) ? 1'($urandom) : sda_mode[0];
         offer_tick(tick);
      end
   endtask

   task automatic run_transaction();
      i2cms_pkg::req_type tick;
      int unsigned roll;
      int unsigned data_count;
      roll = $urandom_range(99);
      if (roll < 8) begin
         // A lone command out of sequence.
         run_command(i2cms_pkg::opcode_type'($urandom_range(3)), random_byte(),
                     1'($urandom), 2'($urandom_range(2)), 30);
      end else if (roll < 12) begin
         repeat ($urandom_range(1, 3)) begin
            tick = i2cms_pkg::req_type'($urandom);
            tick.command_valid = 1'b0;
            offer_tick(tick);
         end
      end else begin
         run_command(i2cms_pkg::OP_START, 8'($urandom), 1'($urandom), SDA_RANDOM, 25);
         data_count = $urandom_range(1, 4);
         repeat (data_count) begin
            run_command($urandom_range(1) ? i2cms_pkg::OP_WRITE : i2cms_pkg::OP_READ,
                        random_byte(), 1'($urandom), 2'($urandom_range(2)), 25);
         end
         // Now and then the stop is left out, as on a repeated start.
         if (roll >= 20) begin
            run_command(i2cms_pkg::OP_STOP, 8'($urandom), 1'($urandom), SDA_RANDOM, 25);
         end
      end
   endtask

   initial begin
      i2cms_pkg::req_type tick;
      int unsigned target;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed: idle tick with every data bit set, a start that sees commands
      // while busy, a write of all ones answered by NACK, a read of all zeros
      // with ACK, and a stop.
      tick = '1;
      tick.command_valid = 1'b0;
      offer_tick(tick);
      run_command(i2cms_pkg::OP_START, 8'h00, 1'b0, SDA_RELEASED, 100);
      run_command(i2cms_pkg::OP_WRITE, 8'hFF, 1'b0, SDA_RELEASED, 0);
      run_command(i2cms_pkg::OP_READ, 8'h00, 1'b1, SDA_LOW, 0);
      run_command(i2cms_pkg::OP_STOP, 8'hFF, 1'b1, SDA_LOW, 0);

      for (int phase_sel = 0; phase_sel < 3; phase_sel++) begin
         case (phase_sel)
            0: begin
               send_idle_pct = 26;
               recv_idle_pct <= 46;
            end
            1: begin
               send_idle_pct = 46;
               recv_idle_pct <= 26;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct <= 0;
               hold_request  <= 1'b1;
            end
         endcase
         target = ticks_sent + TICKS_PER_RUN;
         while (ticks_sent < target) begin
            run_transaction();
         end
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (lines_outstanding != 0) begin
         @(posedge clock);
      end
      repeat (5) @(posedge clock);
      if (mismatch_count == 0 && lines_outstanding == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
